### rtl/oate_pkg.sv
// Package for the ordered array table engine.
// Holds the transaction structs, request and status codes, and the command and
// status structs that join the controller to the datapath. No dependencies.
package oate_pkg;

    // Field widths of the request and result transactions.
    localparam int WORD_WIDTH       = 32;
    localparam int CAPACITY_DEFAULT = 64;
    localparam int REQ_W            = 3;
    localparam int POS_W            = 7;
    localparam int IDX_W            = 6;
    localparam int CNT_W            = 7;

    // Request codes. Code 7 is unused and is answered as an invalid position.
    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR   = 3'd0,
        REQ_READ    = 3'd1,
        REQ_INSERT  = 3'd2,
        REQ_DELETE  = 3'd3,
        REQ_SEARCH  = 3'd4,
        REQ_MAXMIN  = 3'd5,
        REQ_REVERSE = 3'd6
    } req_code_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_POS   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // Request transaction.
    typedef struct packed {
        logic [REQ_W-1:0]              req_type;
        logic [POS_W-1:0]              position;
        logic signed [WORD_WIDTH-1:0]  value;
    } request_t;

    // Result transaction.
    typedef struct packed {
        status_t                       status;
        logic [IDX_W-1:0]              index;
        logic signed [WORD_WIDTH-1:0]  data_word;
        logic signed [WORD_WIDTH-1:0]  min_word;
        logic [CNT_W-1:0]              entry_count;
        logic                          last;
    } result_t;

    // Source of the word written into the table memory.
    typedef enum logic [1:0] {
        WSRC_VALUE = 2'd0,
        WSRC_RD_A  = 2'd1,
        WSRC_RD_B  = 2'd2
    } wsrc_t;

    // Update of the entry count.
    typedef enum logic [1:0] {
        CNT_HOLD  = 2'd0,
        CNT_CLEAR = 2'd1,
        CNT_INC   = 2'd2,
        CNT_DEC   = 2'd3
    } cnt_op_t;

    // Update of the maximum and minimum accumulators.
    typedef enum logic [1:0] {
        ACC_NONE   = 2'd0,
        ACC_INIT   = 2'd1,
        ACC_UPDATE = 2'd2
    } acc_op_t;

    // Kind of result the datapath issues in a cycle.
    typedef enum logic [2:0] {
        EMIT_NONE       = 3'd0,
        EMIT_STATUS     = 3'd1,
        EMIT_ENTRY      = 3'd2,
        EMIT_SEARCH_END = 3'd3,
        EMIT_MAXMIN     = 3'd4
    } emit_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic    load_req;
        logic    rd_en;
        logic    wr_en;
        wsrc_t   wr_src;
        cnt_op_t cnt_op;
        acc_op_t acc_op;
        logic    pend_clear;
        logic    search_step;
        emit_t   emit;
        status_t status;
        logic    last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [POS_W-1:0] position;
    } dp_stat_t;

endpackage

### rtl/oate_datapath.sv
// Datapath of the ordered array table engine: table memory, entry count,
// request register, max/min accumulators, pending search hit and result register.
// Depends on oate_pkg.
module oate_datapath
    import oate_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  request_t                     request,
    input  dp_cmd_t                      cmd,
    input  logic [$clog2(CAPACITY)-1:0]  rd_addr_a,
    input  logic [$clog2(CAPACITY)-1:0]  rd_addr_b,
    input  logic [$clog2(CAPACITY)-1:0]  wr_addr,
    input  logic [$clog2(CAPACITY)-1:0]  scan_idx,
    output dp_stat_t                     stat,
    output logic [$clog2(CAPACITY+1)-1:0] count,
    output logic                         result_valid,
    output result_t                      result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    request_t                     req_reg;
    logic [CW-1:0]                count_reg, count_next;
    logic signed [WORD_WIDTH-1:0] mem [CAPACITY];
    logic signed [WORD_WIDTH-1:0] rd_a_reg, rd_b_reg, wr_data;
    logic signed [WORD_WIDTH-1:0] max_reg, max_next, min_reg, min_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [AW-1:0]                pend_idx_reg, pend_idx_next;
    result_t                      result_reg, result_next;
    logic                         result_valid_reg, result_valid_next;
    logic                         hit;

    // Request register, loaded when a transaction is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= request;
        end
    end

    assign stat.req_type = req_reg.req_type;
    assign stat.position = req_reg.position;

    // Entry count update.
    always_comb
    begin
        case (cmd.cnt_op)
            CNT_CLEAR: count_next = '0;
            CNT_INC:   count_next = count_reg + CW'(1);
            CNT_DEC:   count_next = count_reg - CW'(1);
            default:   count_next = count_reg;
        endcase
    end

    assign count = count_reg;

    // Write data selection for the table memory.
    always_comb
    begin
        case (cmd.wr_src)
            WSRC_RD_A: wr_data = rd_a_reg;
            WSRC_RD_B: wr_data = rd_b_reg;
            default:   wr_data = req_reg.value;
        endcase
    end

    // Table memory: one write port and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    // The search key matches the entry now held in read port A.
    assign hit = (rd_a_reg == req_reg.value);

    // Maximum and minimum accumulators for the max and min request.
    always_comb
    begin
        max_next = max_reg;
        min_next = min_reg;
        case (cmd.acc_op)
            ACC_INIT:
            begin
                max_next = rd_a_reg;
                min_next = rd_a_reg;
            end
            ACC_UPDATE:
            begin
                if (rd_a_reg > max_reg)
                begin
                    max_next = rd_a_reg;
                end
                if (rd_a_reg < min_reg)
                begin
                    min_next = rd_a_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        max_reg <= max_next;
        min_reg <= min_next;
    end

    // The latest search match is held back until the next match or the end of
    // the scan tells whether it is the final result.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        if (cmd.pend_clear)
        begin
            pend_valid_next = 1'b0;
        end
        if (cmd.search_step && hit)
        begin
            pend_valid_next = 1'b1;
            pend_idx_next   = scan_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
    end

    // Result formation.
    always_comb
    begin
        result_next             = '0;
        result_next.entry_count = CNT_W'(count_next);
        result_valid_next       = 1'b0;
        case (cmd.emit)
            EMIT_STATUS:
            begin
                result_valid_next  = 1'b1;
                result_next.status = cmd.status;
                result_next.last   = 1'b1;
            end
            EMIT_ENTRY:
            begin
                result_valid_next     = 1'b1;
                result_next.index     = IDX_W'(scan_idx);
                result_next.data_word = rd_a_reg;
                result_next.last      = cmd.last;
            end
            EMIT_SEARCH_END:
            begin
                result_valid_next = 1'b1;
                result_next.last  = 1'b1;
                if (pend_valid_reg)
                begin
                    result_next.index     = IDX_W'(pend_idx_reg);
                    result_next.data_word = req_reg.value;
                end
                else
                begin
                    result_next.status = ST_NOT_FOUND;
                end
            end
            EMIT_MAXMIN:
            begin
                result_valid_next     = 1'b1;
                result_next.data_word = max_reg;
                result_next.min_word  = min_reg;
                result_next.last      = 1'b1;
            end
            EMIT_NONE:
            begin
                // A new match releases the held one as a non-final result.
                if (cmd.search_step && hit && pend_valid_reg)
                begin
                    result_valid_next     = 1'b1;
                    result_next.index     = IDX_W'(pend_idx_reg);
                    result_next.data_word = req_reg.value;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/oate_controller.sv
// Controller of the ordered array table engine: decodes a request and walks the
// table one entry per cycle, driving memory addresses and datapath commands.
// Depends on oate_pkg.
module oate_controller
    import oate_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  dp_stat_t                      stat,
    input  logic [$clog2(CAPACITY+1)-1:0] count,
    output dp_cmd_t                       cmd,
    output logic [$clog2(CAPACITY)-1:0]   rd_addr_a,
    output logic [$clog2(CAPACITY)-1:0]   rd_addr_b,
    output logic [$clog2(CAPACITY)-1:0]   wr_addr,
    output logic [$clog2(CAPACITY)-1:0]   scan_idx
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (POS_W > CW) ? POS_W : CW;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DECODE   = 9'b000000010,
        S_SCAN     = 9'b000000100,
        S_FINISH   = 9'b000001000,
        S_SHIFT_UP = 9'b000010000,
        S_PUT      = 9'b000100000,
        S_SHIFT_DN = 9'b001000000,
        S_SWAP_A   = 9'b010000000,
        S_SWAP_B   = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] ptrb_reg, ptrb_next;
    logic [CMP_W-1:0] pos_ext, cnt_ext, ptr_ext;
    logic [AW-1:0] last_addr;
    logic [CW-1:0] gap;
    logic          at_last;

    // Comparison helpers on the position, the count and the walk pointers.
    assign pos_ext   = CMP_W'(stat.position);
    assign cnt_ext   = CMP_W'(count);
    assign ptr_ext   = CMP_W'(ptr_reg);
    assign last_addr = AW'(count - CW'(1));
    assign at_last   = (CW'(ptr_reg) == (count - CW'(1)));
    assign gap       = CW'(ptrb_reg) - CW'(ptr_reg);

    assign busy     = (state_reg != S_IDLE);
    assign scan_idx = ptr_reg;

    // Next state, pointer updates and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        ptrb_next  = ptrb_reg;
        rd_addr_a  = ptr_reg;
        rd_addr_b  = ptrb_reg;
        wr_addr    = ptr_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (stat.req_type)
                    REQ_CLEAR:
                    begin
                        cmd.cnt_op = CNT_CLEAR;
                        cmd.emit   = EMIT_STATUS;
                    end
                    REQ_READ, REQ_SEARCH, REQ_MAXMIN:
                    begin
                        if (count == '0)
                        begin
                            cmd.emit = EMIT_STATUS;
                            if (stat.req_type == REQ_SEARCH)
                            begin
                                cmd.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                cmd.status = ST_EMPTY;
                            end
                        end
                        else
                        begin
                            rd_addr_a      = '0;
                            cmd.rd_en      = 1'b1;
                            cmd.pend_clear = 1'b1;
                            ptr_next       = '0;
                            state_next     = S_SCAN;
                        end
                    end
                    REQ_INSERT:
                    begin
                        if (pos_ext > cnt_ext)
                        begin
                            cmd.emit   = EMIT_STATUS;
                            cmd.status = ST_BAD_POS;
                        end
                        else if (cnt_ext >= CMP_W'(CAPACITY))
                        begin
                            cmd.emit   = EMIT_STATUS;
                            cmd.status = ST_FULL;
                        end
                        else if (pos_ext == cnt_ext)
                        begin
                            // Append: nothing to shift.
                            cmd.wr_en  = 1'b1;
                            cmd.wr_src = WSRC_VALUE;
                            wr_addr    = AW'(pos_ext);
                            cmd.cnt_op = CNT_INC;
                            cmd.emit   = EMIT_STATUS;
                        end
                        else
                        begin
                            rd_addr_a  = last_addr;
                            cmd.rd_en  = 1'b1;
                            ptr_next   = last_addr;
                            state_next = S_SHIFT_UP;
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (pos_ext >= cnt_ext)
                        begin
                            cmd.emit   = EMIT_STATUS;
                            cmd.status = ST_BAD_POS;
                        end
                        else if (pos_ext == (cnt_ext - CMP_W'(1)))
                        begin
                            // Removing the last entry moves nothing.
                            cmd.cnt_op = CNT_DEC;
                            cmd.emit   = EMIT_STATUS;
                        end
                        else
                        begin
                            rd_addr_a  = AW'(pos_ext + CMP_W'(1));
                            cmd.rd_en  = 1'b1;
                            ptr_next   = AW'(pos_ext + CMP_W'(1));
                            state_next = S_SHIFT_DN;
                        end
                    end
                    REQ_REVERSE:
                    begin
                        if (count < CW'(2))
                        begin
                            cmd.emit = EMIT_STATUS;
                        end
                        else
                        begin
                            rd_addr_a  = '0;
                            rd_addr_b  = last_addr;
                            cmd.rd_en  = 1'b1;
                            ptr_next   = '0;
                            ptrb_next  = last_addr;
                            state_next = S_SWAP_A;
                        end
                    end
                    default:
                    begin
                        cmd.emit   = EMIT_STATUS;
                        cmd.status = ST_BAD_POS;
                    end
                endcase
            end
            S_SCAN:
            begin
                // Read port A holds entry ptr; prefetch the next one.
                rd_addr_a = ptr_reg + AW'(1);
                cmd.rd_en = !at_last;
                case (stat.req_type)
                    REQ_READ:
                    begin
                        cmd.emit = EMIT_ENTRY;
                        cmd.last = at_last;
                    end
                    REQ_SEARCH:
                    begin
                        cmd.search_step = 1'b1;
                    end
                    default:
                    begin
                        if (ptr_reg == '0)
                        begin
                            cmd.acc_op = ACC_INIT;
                        end
                        else
                        begin
                            cmd.acc_op = ACC_UPDATE;
                        end
                    end
                endcase
                if (at_last)
                begin
                    if (stat.req_type == REQ_READ)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            S_FINISH:
            begin
                if (stat.req_type == REQ_SEARCH)
                begin
                    cmd.emit = EMIT_SEARCH_END;
                end
                else
                begin
                    cmd.emit = EMIT_MAXMIN;
                end
                state_next = S_IDLE;
            end
            S_SHIFT_UP:
            begin
                // Move entry ptr up by one, reading the one below it.
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WSRC_RD_A;
                wr_addr    = ptr_reg + AW'(1);
                if (ptr_ext == pos_ext)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr_a = ptr_reg - AW'(1);
                    ptr_next  = ptr_reg - AW'(1);
                end
            end
            S_PUT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WSRC_VALUE;
                wr_addr    = ptr_reg;
                cmd.cnt_op = CNT_INC;
                cmd.emit   = EMIT_STATUS;
                state_next = S_IDLE;
            end
            S_SHIFT_DN:
            begin
                // Move entry ptr down by one, reading the one above it.
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WSRC_RD_A;
                wr_addr    = ptr_reg - AW'(1);
                if (at_last)
                begin
                    cmd.cnt_op = CNT_DEC;
                    cmd.emit   = EMIT_STATUS;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr_a = ptr_reg + AW'(1);
                    ptr_next  = ptr_reg + AW'(1);
                end
            end
            S_SWAP_A:
            begin
                // Low slot takes the high word; both read words are held.
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WSRC_RD_B;
                wr_addr    = ptr_reg;
                state_next = S_SWAP_B;
            end
            S_SWAP_B:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WSRC_RD_A;
                wr_addr    = ptrb_reg;
                if (gap > CW'(2))
                begin
                    cmd.rd_en  = 1'b1;
                    rd_addr_a  = ptr_reg + AW'(1);
                    rd_addr_b  = ptrb_reg - AW'(1);
                    ptr_next   = ptr_reg + AW'(1);
                    ptrb_next  = ptrb_reg - AW'(1);
                    state_next = S_SWAP_A;
                end
                else
                begin
                    cmd.emit   = EMIT_STATUS;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and walk pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
            ptrb_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            ptrb_reg  <= ptrb_next;
        end
    end

endmodule

### rtl/ordered_array_table_engine.sv
// Top level of the ordered array table engine.
// Joins oate_controller and oate_datapath; depends on oate_pkg.
//
//   channel   handshake               payload                  direction
//   request   start, accepted at      request   (request_t)     in
//             start & !busy
//   result    result_valid, one-cycle result    (result_t)      out
//             strobe, never stalled
//
// A request is accepted while idle and decoded in the next cycle. Clear, invalid
// requests, appends, removal of the last entry and empty or one-entry cases then
// finish. Read-out, search and max/min walk the n entries in use at one per cycle
// (search and max/min then take a finish step), insert at p moves n-p entries and
// then writes the new word, delete at p moves n-p-1, and reverse swaps each of the
// n/2 pairs with a low-slot write and then a high-slot write. Each result is
// registered before it leaves; busy stays high until the final one is formed.
// Reset clears the count; table contents stay undefined.
module ordered_array_table_engine
    import oate_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     result_valid,
    output result_t  result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    dp_cmd_t       cmd;
    dp_stat_t      stat;
    logic [CW-1:0] count;
    logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr, scan_idx;

    // Sequencing of each request.
    oate_controller #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .stat      (stat),
        .count     (count),
        .cmd       (cmd),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr_addr   (wr_addr),
        .scan_idx  (scan_idx)
    );

    // Table storage and result formation.
    oate_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .rd_addr_a    (rd_addr_a),
        .rd_addr_b    (rd_addr_b),
        .wr_addr      (wr_addr),
        .scan_idx     (scan_idx),
        .stat         (stat),
        .count        (count),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
